@@ hw/rtl/bsoc_pkg.sv @@
// Shared widths, constants, coefficient tables and control-word types for the SOC estimator.
package bsoc_pkg;

   // Fixed-point format of the state of charge.
   localparam int FRAC_BITS = 30;

   // Field and datapath widths.
   localparam int CUR_W    = 24;
   localparam int SUM_W    = CUR_W + 1;
   localparam int LEVEL_W  = 32;
   localparam int CFG_W    = 31;
   localparam int SCALE_W  = 32;
   localparam int VOLT_W   = 28;
   localparam int RES_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int MAG_W    = 34;
   localparam int HALF_W   = MAG_W / 2;
   localparam int PART_W   = HALF_W + SCALE_W;
   localparam int PROD_W   = 64;
   localparam int ACC_W    = 34;
   localparam int HSUM_W   = ACC_W + 2;
   localparam int COEF_W   = 29;
   localparam int DELTA_W  = 24;
   localparam int STEP_W   = 5;
   localparam int COEF_IDX_W = 3;

   // Right shift that turns the charge product into SOC units.
   localparam int CHG_SHIFT = PROD_W - FRAC_BITS;

   // SOC limits, held at accumulator width for the compares.
   localparam longint LEVEL_MAX_VAL =
      (FRAC_BITS >= 31) ? 64'sh7FFF_FFFF : (64'sd1 <<< FRAC_BITS);
   localparam longint LEVEL_MIN_VAL = -(64'sd1 <<< 31);
   localparam logic signed [ACC_W-1:0] LEVEL_MAX = ACC_W'(LEVEL_MAX_VAL);
   localparam logic signed [ACC_W-1:0] LEVEL_MIN = ACC_W'(LEVEL_MIN_VAL);

   // Horner accumulator limits.
   localparam logic signed [HSUM_W-1:0] HORN_MAX = HSUM_W'(64'sd1 <<< 32);
   localparam logic signed [HSUM_W-1:0] HORN_MIN = HSUM_W'(-(64'sd1 <<< 32));

   // Output limits.
   localparam logic signed [ACC_W-1:0] VOLT_MAX = ACC_W'((64'sd1 <<< (VOLT_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] VOLT_MIN = ACC_W'(-(64'sd1 <<< (VOLT_W - 1)));
   localparam logic signed [HSUM_W-1:0] RES_MAX = HSUM_W'((64'sd1 <<< (RES_W - 1)) - 1);
   localparam logic signed [HSUM_W-1:0] RES_MIN = HSUM_W'(-(64'sd1 <<< (RES_W - 1)));

   // Reset values of the configuration registers.
   localparam logic [SCALE_W-1:0] SCALE_RESET = '0;
   localparam logic [CFG_W-1:0]   STOP_RESET  = 31'd53687091;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP  = 2'd2;

   // Index of the leading coefficient.
   localparam logic [COEF_IDX_W-1:0] COEF_LEAD = 3'd0;

   // Sequencer flow control.
   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_ACCEPT,
      SEQ_DELIVER,
      SEQ_JUMP
   } seq_type;

   // Shared multiplier operation.
   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_LO,
      MUL_HI
   } mul_type;

   // Multiplier operand A source.
   typedef enum logic {
      A_VOLT,
      A_RES
   } asel_type;

   // Multiplier operand B source.
   typedef enum logic {
      B_SCALE,
      B_LEVEL
   } bsel_type;

   // Register update performed by a step.
   typedef enum logic [2:0] {
      UPD_NONE,
      UPD_TAKE,
      UPD_SOC,
      UPD_PREP,
      UPD_HORN_V,
      UPD_HORN_R,
      UPD_LOAD_V,
      UPD_LOAD_R
   } upd_type;

   // One microcode word.
   typedef struct packed {
      seq_type                 seq;
      mul_type                 mul;
      asel_type                a_sel;
      bsel_type                b_sel;
      upd_type                 upd;
      logic [COEF_IDX_W-1:0]   coef_idx;
      logic [STEP_W-1:0]       target;
   } ctrl_type;

   // Handshake conditions that steer the sequencer's conditional jumps.
   typedef struct packed {
      logic in_go;
      logic out_go;
   } cond_type;

   // Open-circuit voltage coefficients, Q.20, leading term first.
   function automatic logic signed [COEF_W-1:0] volt_coef(input logic [COEF_IDX_W-1:0] idx);
      logic signed [COEF_W-1:0] c;
      case (idx)
         3'd0:    c = -29'sd13904118;
         3'd1:    c = 29'sd28730982;
         3'd2:    c = -29'sd18863882;
         3'd3:    c = 29'sd4714398;
         3'd4:    c = 29'sd3617587;
         default: c = '0;
      endcase
      return c;
   endfunction

   // Series resistance coefficients, Q.30, leading term first.
   function automatic logic signed [COEF_W-1:0] res_coef(input logic [COEF_IDX_W-1:0] idx);
      logic signed [COEF_W-1:0] c;
      case (idx)
         3'd0:    c = -29'sd113279762;
         3'd1:    c = 29'sd211312391;
         3'd2:    c = -29'sd120151710;
         3'd3:    c = 29'sd17255031;
         3'd4:    c = 29'sd3346853;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

@@ hw/rtl/bsoc_sequencer.sv @@
// Microcode step counter and program ROM for the SOC estimator datapath.
module bsoc_sequencer
   import bsoc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cond_type cond,
   output ctrl_type ctrl
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;

   // Builds one control word.
   function automatic ctrl_type mk(input seq_type s, input mul_type m, input asel_type a,
                                   input bsel_type b, input upd_type u,
                                   input logic [COEF_IDX_W-1:0] k,
                                   input logic [STEP_W-1:0] t);
      ctrl_type w;
      w.seq      = s;
      w.mul      = m;
      w.a_sel    = a;
      w.b_sel    = b;
      w.upd      = u;
      w.coef_idx = k;
      w.target   = t;
      return w;
   endfunction

   // Program: take a sample, form the charge product, update the SOC, then run both
   // Horner chains interleaved on the one multiplier and deliver the result.
   always_comb begin
      case (step_ff)
         5'd0:    ctrl = mk(SEQ_ACCEPT,  MUL_IDLE, A_VOLT, B_SCALE, UPD_TAKE,   3'd0, 5'd0);
         5'd1:    ctrl = mk(SEQ_NEXT,    MUL_LO,   A_VOLT, B_SCALE, UPD_NONE,   3'd0, 5'd0);
         5'd2:    ctrl = mk(SEQ_NEXT,    MUL_HI,   A_VOLT, B_SCALE, UPD_NONE,   3'd0, 5'd0);
         5'd3:    ctrl = mk(SEQ_NEXT,    MUL_IDLE, A_VOLT, B_SCALE, UPD_SOC,    3'd0, 5'd0);
         5'd4:    ctrl = mk(SEQ_NEXT,    MUL_IDLE, A_VOLT, B_LEVEL, UPD_PREP,   3'd0, 5'd0);
         // First Horner round.
         5'd5:    ctrl = mk(SEQ_NEXT,    MUL_LO,   A_VOLT, B_LEVEL, UPD_NONE,   3'd0, 5'd0);
         5'd6:    ctrl = mk(SEQ_NEXT,    MUL_HI,   A_VOLT, B_LEVEL, UPD_NONE,   3'd0, 5'd0);
         5'd7:    ctrl = mk(SEQ_NEXT,    MUL_LO,   A_RES,  B_LEVEL, UPD_HORN_V, 3'd1, 5'd0);
         5'd8:    ctrl = mk(SEQ_NEXT,    MUL_HI,   A_RES,  B_LEVEL, UPD_LOAD_V, 3'd0, 5'd0);
         // Second Horner round.
         5'd9:    ctrl = mk(SEQ_NEXT,    MUL_LO,   A_VOLT, B_LEVEL, UPD_HORN_R, 3'd1, 5'd0);
         5'd10:   ctrl = mk(SEQ_NEXT,    MUL_HI,   A_VOLT, B_LEVEL, UPD_LOAD_R, 3'd0, 5'd0);
         5'd11:   ctrl = mk(SEQ_NEXT,    MUL_LO,   A_RES,  B_LEVEL, UPD_HORN_V, 3'd2, 5'd0);
         5'd12:   ctrl = mk(SEQ_NEXT,    MUL_HI,   A_RES,  B_LEVEL, UPD_LOAD_V, 3'd0, 5'd0);
         // Third Horner round.
         5'd13:   ctrl = mk(SEQ_NEXT,    MUL_LO,   A_VOLT, B_LEVEL, UPD_HORN_R, 3'd2, 5'd0);
         5'd14:   ctrl = mk(SEQ_NEXT,    MUL_HI,   A_VOLT, B_LEVEL, UPD_LOAD_R, 3'd0, 5'd0);
         5'd15:   ctrl = mk(SEQ_NEXT,    MUL_LO,   A_RES,  B_LEVEL, UPD_HORN_V, 3'd3, 5'd0);
         5'd16:   ctrl = mk(SEQ_NEXT,    MUL_HI,   A_RES,  B_LEVEL, UPD_LOAD_V, 3'd0, 5'd0);
         // Fourth Horner round.
         5'd17:   ctrl = mk(SEQ_NEXT,    MUL_LO,   A_VOLT, B_LEVEL, UPD_HORN_R, 3'd3, 5'd0);
         5'd18:   ctrl = mk(SEQ_NEXT,    MUL_HI,   A_VOLT, B_LEVEL, UPD_LOAD_R, 3'd0, 5'd0);
         5'd19:   ctrl = mk(SEQ_NEXT,    MUL_LO,   A_RES,  B_LEVEL, UPD_HORN_V, 3'd4, 5'd0);
         5'd20:   ctrl = mk(SEQ_NEXT,    MUL_HI,   A_RES,  B_LEVEL, UPD_NONE,   3'd0, 5'd0);
         5'd21:   ctrl = mk(SEQ_NEXT,    MUL_IDLE, A_RES,  B_LEVEL, UPD_HORN_R, 3'd4, 5'd0);
         5'd22:   ctrl = mk(SEQ_DELIVER, MUL_IDLE, A_VOLT, B_SCALE, UPD_NONE,   3'd0, 5'd0);
         default: ctrl = mk(SEQ_JUMP,    MUL_IDLE, A_VOLT, B_SCALE, UPD_NONE,   3'd0, 5'd0);
      endcase
   end

   // Step counter with conditional holds and jumps.
   always_comb begin
      case (ctrl.seq)
         SEQ_NEXT:    step_in = step_ff + 1'b1;
         SEQ_ACCEPT:  step_in = cond.in_go ? step_ff + 1'b1 : step_ff;
         SEQ_DELIVER: step_in = cond.out_go ? ctrl.target : step_ff;
         SEQ_JUMP:    step_in = ctrl.target;
         default:     step_in = ctrl.target;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

@@ hw/rtl/battery_soc_ocv_estimator_core.sv @@
// Top level of the coulomb-counting SOC estimator with OCV and resistance polynomials.
//
// Each accepted current sample lowers the Q2.30 state of charge by the trapezoidal
// charge, then evaluates the open-circuit voltage and series resistance quartics at
// the new SOC and reports SOC, both values and the empty flag as one transaction.
// The microcode program runs nine products through one 17 x 32 bit multiplier, two
// passes each, with the two Horner chains interleaved, so a new sample is taken only
// after the program has delivered the result of the one before. The result register
// lets the next sample start while the previous result still waits; the program holds
// at its last step only if the result before it has not been taken. Writing start_soc
// reloads the SOC and clears the previous current; the user must write configuration
// only while no transaction is in flight, as the block itself does not enforce it.
module battery_soc_ocv_estimator_core
   import bsoc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   // Sample channel.
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [CUR_W-1:0]      req_current_sample,
   // Result channel.
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [LEVEL_W-1:0]    rsp_charge_level,
   output logic signed [VOLT_W-1:0]     rsp_open_voltage,
   output logic signed [RES_W-1:0]      rsp_series_resistance,
   output logic                         rsp_empty_flag,
   // Configuration write channel.
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data
);

   ctrl_type ctrl;
   cond_type cond;

   // Architectural state and configuration.
   logic signed [LEVEL_W-1:0] soc_ff, soc_in;
   logic signed [CUR_W-1:0]   prev_ff, prev_in;
   logic [SCALE_W-1:0]        scale_ff, scale_in;
   logic [CFG_W-1:0]          stop_ff, stop_in;

   // Datapath working registers.
   logic [MAG_W-1:0]          mag_v_ff, mag_v_in;
   logic [MAG_W-1:0]          mag_r_ff, mag_r_in;
   logic                      sgn_v_ff, sgn_v_in;
   logic                      sgn_r_ff, sgn_r_in;
   logic [LEVEL_W-1:0]        xmag_ff, xmag_in;
   logic                      xneg_ff, xneg_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_v_ff, acc_v_in;
   logic signed [ACC_W-1:0]   acc_r_ff, acc_r_in;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [LEVEL_W-1:0] level_out_ff, level_out_in;
   logic signed [VOLT_W-1:0]  volt_out_ff, volt_out_in;
   logic signed [RES_W-1:0]   res_out_ff, res_out_in;
   logic                      flag_out_ff, flag_out_in;

   // Combinational datapath signals.
   logic                      csr_go;
   logic signed [SUM_W-1:0]   cur_sum;
   logic [SUM_W-1:0]          cur_mag;
   logic [MAG_W-1:0]          a_mag;
   logic [HALF_W-1:0]         a_half;
   logic [SCALE_W-1:0]        b_op;
   logic [PART_W-1:0]         part;
   logic [PROD_W-1:0]         chg_round;
   logic [DELTA_W-1:0]        chg_mag;
   logic signed [ACC_W-1:0]   chg_delta;
   logic signed [ACC_W-1:0]   soc_diff;
   logic signed [ACC_W-1:0]   soc_clamped;
   logic signed [ACC_W-1:0]   start_ext;
   logic signed [LEVEL_W-1:0] start_level;
   logic [PROD_W-1:0]         horn_round;
   logic [MAG_W-1:0]          horn_mag;
   logic                      horn_neg;
   logic signed [HSUM_W-1:0]  horn_t;
   logic signed [COEF_W-1:0]  horn_coef;
   logic signed [HSUM_W-1:0]  horn_total;
   logic signed [ACC_W-1:0]   horn_acc;
   logic signed [COEF_W-1:0]  volt_lead;
   logic signed [COEF_W-1:0]  res_lead;
   logic signed [HSUM_W-1:0]  res_scaled;
   logic signed [VOLT_W-1:0]  volt_sat;
   logic signed [RES_W-1:0]   res_sat;
   logic                      empty_now;

   // Magnitude of a signed accumulator value.
   function automatic logic [MAG_W-1:0] mag_of(input logic signed [ACC_W-1:0] v);
      return v[ACC_W-1] ? MAG_W'(-v) : MAG_W'(v);
   endfunction

   bsoc_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctrl  (ctrl)
   );

   // Handshakes.
   assign req_ready  = (ctrl.seq == SEQ_ACCEPT);
   assign csr_ready  = 1'b1;
   assign csr_go     = csr_valid & csr_ready;
   assign cond.in_go  = req_valid & req_ready;
   assign cond.out_go = (ctrl.seq == SEQ_DELIVER) && (!rsp_valid_ff || rsp_ready);

   // Trapezoidal current sum and its magnitude.
   assign cur_sum = $signed({req_current_sample[CUR_W-1], req_current_sample})
                  + $signed({prev_ff[CUR_W-1], prev_ff});
   assign cur_mag = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);

   // Shared multiplier: one half of operand A per pass.
   assign a_mag  = (ctrl.a_sel == A_VOLT) ? mag_v_ff : mag_r_ff;
   assign a_half = (ctrl.mul == MUL_HI) ? a_mag[MAG_W-1:HALF_W] : a_mag[HALF_W-1:0];
   assign b_op   = (ctrl.b_sel == B_SCALE) ? scale_ff : xmag_ff;
   assign part   = PART_W'(a_half) * PART_W'(b_op);

   // Charge delta, rounded half away from zero, and the saturated new SOC.
   assign chg_round = prod_ff + (PROD_W'(1) << (CHG_SHIFT - 1));
   assign chg_mag   = DELTA_W'(chg_round >> CHG_SHIFT);
   assign chg_delta = sgn_v_ff ? -$signed(ACC_W'(chg_mag)) : $signed(ACC_W'(chg_mag));
   assign soc_diff  = ACC_W'(soc_ff) - chg_delta;

   always_comb begin
      if (soc_diff < LEVEL_MIN) begin
         soc_clamped = LEVEL_MIN;
      end else if (soc_diff > LEVEL_MAX) begin
         soc_clamped = LEVEL_MAX;
      end else begin
         soc_clamped = soc_diff;
      end
   end

   // Start value, limited to full charge.
   assign start_ext   = $signed(ACC_W'(csr_data[CFG_W-1:0]));
   assign start_level = (start_ext > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(start_ext);

   // Horner step: round(acc * x / 2^FRAC_BITS) plus the next coefficient, saturated.
   assign horn_round = prod_ff + (PROD_W'(1) << (FRAC_BITS - 1));
   assign horn_mag   = MAG_W'(horn_round >> FRAC_BITS);
   assign horn_neg   = ((ctrl.upd == UPD_HORN_V) ? sgn_v_ff : sgn_r_ff) ^ xneg_ff;
   assign horn_t     = horn_neg ? -$signed(HSUM_W'(horn_mag)) : $signed(HSUM_W'(horn_mag));
   assign horn_coef  = (ctrl.upd == UPD_HORN_V) ? volt_coef(ctrl.coef_idx)
                                                 : res_coef(ctrl.coef_idx);
   assign horn_total = horn_t + HSUM_W'(horn_coef);

   always_comb begin
      if (horn_total > HORN_MAX) begin
         horn_acc = ACC_W'(HORN_MAX);
      end else if (horn_total < HORN_MIN) begin
         horn_acc = ACC_W'(HORN_MIN);
      end else begin
         horn_acc = ACC_W'(horn_total);
      end
   end

   assign volt_lead = volt_coef(COEF_LEAD);
   assign res_lead  = res_coef(COEF_LEAD);

   // Output saturation and the empty compare.
   assign res_scaled = HSUM_W'(acc_r_ff) <<< 2;

   always_comb begin
      if (acc_v_ff > VOLT_MAX) begin
         volt_sat = VOLT_W'(VOLT_MAX);
      end else if (acc_v_ff < VOLT_MIN) begin
         volt_sat = VOLT_W'(VOLT_MIN);
      end else begin
         volt_sat = VOLT_W'(acc_v_ff);
      end
      if (res_scaled > RES_MAX) begin
         res_sat = RES_W'(RES_MAX);
      end else if (res_scaled < RES_MIN) begin
         res_sat = RES_W'(RES_MIN);
      end else begin
         res_sat = RES_W'(res_scaled);
      end
   end

   assign empty_now = $signed({soc_ff[LEVEL_W-1], soc_ff}) <= $signed({2'b00, stop_ff});

   // Next-state logic for the datapath, configuration and result register.
   always_comb begin
      soc_in       = soc_ff;
      prev_in      = prev_ff;
      scale_in     = scale_ff;
      stop_in      = stop_ff;
      mag_v_in     = mag_v_ff;
      mag_r_in     = mag_r_ff;
      sgn_v_in     = sgn_v_ff;
      sgn_r_in     = sgn_r_ff;
      xmag_in      = xmag_ff;
      xneg_in      = xneg_ff;
      prod_in      = prod_ff;
      acc_v_in     = acc_v_ff;
      acc_r_in     = acc_r_ff;
      rsp_valid_in = rsp_valid_ff;
      level_out_in = level_out_ff;
      volt_out_in  = volt_out_ff;
      res_out_in   = res_out_ff;
      flag_out_in  = flag_out_ff;

      // Configuration writes; an index past the register list is dropped.
      if (csr_go) begin
         case (csr_index)
            CSR_START: begin
               soc_in  = start_level;
               prev_in = '0;
            end
            CSR_SCALE: scale_in = csr_data[SCALE_W-1:0];
            CSR_STOP:  stop_in  = csr_data[CFG_W-1:0];
            default: ;
         endcase
      end

      // Multiplier passes accumulate into the product register.
      case (ctrl.mul)
         MUL_LO:  prod_in = PROD_W'(part);
         MUL_HI:  prod_in = prod_ff + (PROD_W'(part) << HALF_W);
         default: ;
      endcase

      // Register updates named by the control word.
      case (ctrl.upd)
         UPD_TAKE: begin
            if (cond.in_go) begin
               prev_in  = req_current_sample;
               mag_v_in = MAG_W'(cur_mag);
               sgn_v_in = cur_sum[SUM_W-1];
            end
         end
         UPD_SOC: soc_in = LEVEL_W'(soc_clamped);
         UPD_PREP: begin
            xmag_in  = soc_ff[LEVEL_W-1] ? LEVEL_W'(-soc_ff) : LEVEL_W'(soc_ff);
            xneg_in  = soc_ff[LEVEL_W-1];
            acc_v_in = ACC_W'(volt_lead);
            acc_r_in = ACC_W'(res_lead);
            mag_v_in = mag_of(ACC_W'(volt_lead));
            mag_r_in = mag_of(ACC_W'(res_lead));
            sgn_v_in = volt_lead[COEF_W-1];
            sgn_r_in = res_lead[COEF_W-1];
         end
         UPD_HORN_V: acc_v_in = horn_acc;
         UPD_HORN_R: acc_r_in = horn_acc;
         UPD_LOAD_V: begin
            mag_v_in = mag_of(acc_v_ff);
            sgn_v_in = acc_v_ff[ACC_W-1];
         end
         UPD_LOAD_R: begin
            mag_r_in = mag_of(acc_r_ff);
            sgn_r_in = acc_r_ff[ACC_W-1];
         end
         default: ;
      endcase

      // Result register: load on delivery, clear when taken.
      if (cond.out_go) begin
         rsp_valid_in = 1'b1;
         level_out_in = soc_ff;
         volt_out_in  = volt_sat;
         res_out_in   = res_sat;
         flag_out_in  = empty_now;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         soc_ff       <= LEVEL_W'(LEVEL_MAX);
         prev_ff      <= '0;
         scale_ff     <= SCALE_RESET;
         stop_ff      <= STOP_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         soc_ff       <= soc_in;
         prev_ff      <= prev_in;
         scale_ff     <= scale_in;
         stop_ff      <= stop_in;
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      mag_v_ff     <= mag_v_in;
      mag_r_ff     <= mag_r_in;
      sgn_v_ff     <= sgn_v_in;
      sgn_r_ff     <= sgn_r_in;
      xmag_ff      <= xmag_in;
      xneg_ff      <= xneg_in;
      prod_ff      <= prod_in;
      acc_v_ff     <= acc_v_in;
      acc_r_ff     <= acc_r_in;
      level_out_ff <= level_out_in;
      volt_out_ff  <= volt_out_in;
      res_out_ff   <= res_out_in;
      flag_out_ff  <= flag_out_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_charge_level      = level_out_ff;
   assign rsp_open_voltage      = volt_out_ff;
   assign rsp_series_resistance = res_out_ff;
   assign rsp_empty_flag        = flag_out_ff;

endmodule
